>>> hdl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg: shared types and constants of the signature unpacker
// item layouts, parse phases, verdict codes and the result queue depth
// ----------------------------------------------------------------------------
package dsu_pkg;

  // encoding constants
  localparam int unsigned COORD_BYTES   = 32;
  localparam int unsigned MIN_TOTAL_LEN = 2 * COORD_BYTES;
  localparam logic [7:0]  TAG_SEQ       = 8'h30;
  localparam logic [7:0]  TAG_INT       = 8'h02;

  localparam int unsigned MAX_SIZE_W     = 9;
  localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 9'd128;

  localparam int unsigned IDX_W = 6;

  // result queue, must hold two results per step
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEN,
    PH_RTAG,
    PH_RLEN,
    PH_RVAL,
    PH_STAG,
    PH_SLEN,
    PH_SVAL,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TRUNCATED = 2'd2
  } stat_e;

  typedef enum logic {
    KIND_VALUE   = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] sig_index;
    logic [7:0]       value_byte;
    stat_e            status;
    logic             run_end;
  } res_t;

  // up to two results from one step, in delivery order
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] count;
  } step_res_t;

  function automatic res_t mk_res(kind_e kind, logic [IDX_W-1:0] idx,
                                  logic [7:0] val, stat_e st);
    res_t r;
    r.kind       = kind;
    r.sig_index  = idx;
    r.value_byte = val;
    r.status     = st;
    r.run_end    = 1'b0;
    return r;
  endfunction

endpackage

>>> hdl/dsu_parser.sv
// ----------------------------------------------------------------------------
// dsu_parser: DER field parser
// walks the signature encoding one byte per step and forms its results
// ----------------------------------------------------------------------------
module dsu_parser (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  dsu_pkg::in_item_t                    item_i,
  input  logic [dsu_pkg::MAX_SIZE_W-1:0]       max_size_i,
  output dsu_pkg::step_res_t                   res_o
);

  dsu_pkg::phase_e             phase_q, phase_d;
  logic [7:0]                  total_q, total_d;
  logic [7:0]                  rlen_q, rlen_d;
  logic [7:0]                  slen_q, slen_d;
  logic [7:0]                  cnt_q, cnt_d;
  logic [dsu_pkg::IDX_W-1:0]   pos_q, pos_d;

  logic [7:0] b;
  logic       in_frame;
  logic       len_bad, rlen_bad, slen_bad;
  logic [7:0] fld_len, pad, cnt_inc;
  logic       in_pad, field_done;

  // step events
  logic ev_trunc_old, ev_mal, ev_val, ev_ok, ev_trunc_fin, live_mid;

  assign b        = item_i.data_byte;
  assign in_frame = (phase_q != dsu_pkg::PH_IDLE) && (phase_q != dsu_pkg::PH_DONE);

  assign len_bad  = (b < 8'(dsu_pkg::MIN_TOTAL_LEN))
                 || (({2'b00, b} + 10'd2) > {1'b0, max_size_i});
  assign rlen_bad = (b < 8'(dsu_pkg::COORD_BYTES))
                 || (({1'b0, b} + 9'd2) > {1'b0, total_q});
  assign slen_bad = (b < 8'(dsu_pkg::COORD_BYTES))
                 || (({2'b00, b} + {2'b00, rlen_q} + 10'd4) > {2'b00, total_q});

  assign fld_len    = (phase_q == dsu_pkg::PH_RVAL) ? rlen_q : slen_q;
  assign pad        = fld_len - 8'(dsu_pkg::COORD_BYTES);
  assign in_pad     = cnt_q < pad;
  assign cnt_inc    = cnt_q + 8'd1;
  assign field_done = cnt_inc >= fld_len;

  // event decode
  always_comb begin
    ev_trunc_old = item_i.first && in_frame;
    ev_mal       = 1'b0;
    ev_val       = 1'b0;
    ev_ok        = 1'b0;
    if (item_i.first) begin
      ev_mal = (b != dsu_pkg::TAG_SEQ);
    end else begin
      unique case (phase_q)
        dsu_pkg::PH_LEN:  ev_mal = len_bad;
        dsu_pkg::PH_RTAG: ev_mal = (b != dsu_pkg::TAG_INT);
        dsu_pkg::PH_RLEN: ev_mal = rlen_bad;
        dsu_pkg::PH_STAG: ev_mal = (b != dsu_pkg::TAG_INT);
        dsu_pkg::PH_SLEN: ev_mal = slen_bad;
        dsu_pkg::PH_RVAL, dsu_pkg::PH_SVAL: begin
          if (in_pad) begin
            ev_mal = (b != 8'd0);
          end else begin
            ev_val = 1'b1;
          end
          ev_ok = !ev_mal && field_done && (phase_q == dsu_pkg::PH_SVAL);
        end
        default: ;
      endcase
    end
    live_mid     = item_i.first ? !ev_mal : (in_frame && !ev_mal && !ev_ok);
    ev_trunc_fin = item_i.final_byte && live_mid;
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    total_d = total_q;
    rlen_d  = rlen_q;
    slen_d  = slen_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    if (item_i.first) begin
      total_d = '0;
      rlen_d  = '0;
      slen_d  = '0;
      cnt_d   = '0;
      pos_d   = '0;
      phase_d = ev_mal ? dsu_pkg::PH_DONE : dsu_pkg::PH_LEN;
    end else begin
      unique case (phase_q)
        dsu_pkg::PH_LEN: begin
          if (ev_mal) begin
            phase_d = dsu_pkg::PH_DONE;
          end else begin
            total_d = b;
            phase_d = dsu_pkg::PH_RTAG;
          end
        end
        dsu_pkg::PH_RTAG: phase_d = ev_mal ? dsu_pkg::PH_DONE : dsu_pkg::PH_RLEN;
        dsu_pkg::PH_RLEN: begin
          if (ev_mal) begin
            phase_d = dsu_pkg::PH_DONE;
          end else begin
            rlen_d  = b;
            cnt_d   = '0;
            phase_d = dsu_pkg::PH_RVAL;
          end
        end
        dsu_pkg::PH_STAG: phase_d = ev_mal ? dsu_pkg::PH_DONE : dsu_pkg::PH_SLEN;
        dsu_pkg::PH_SLEN: begin
          if (ev_mal) begin
            phase_d = dsu_pkg::PH_DONE;
          end else begin
            slen_d  = b;
            cnt_d   = '0;
            phase_d = dsu_pkg::PH_SVAL;
          end
        end
        dsu_pkg::PH_RVAL, dsu_pkg::PH_SVAL: begin
          if (ev_mal) begin
            phase_d = dsu_pkg::PH_DONE;
          end else begin
            if (ev_val) begin
              pos_d = pos_q + 1'b1;
            end
            cnt_d = cnt_inc;
            if (field_done) begin
              cnt_d   = '0;
              phase_d = (phase_q == dsu_pkg::PH_RVAL) ? dsu_pkg::PH_STAG
                                                      : dsu_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
    if (ev_trunc_fin) begin
      phase_d = dsu_pkg::PH_DONE;
    end
  end

  // results, in order: old frame cut, malformed, value, ok, end of input
  always_comb begin
    dsu_pkg::res_t r0, r1, cur;
    logic [1:0]    n;
    r0  = dsu_pkg::mk_res(dsu_pkg::KIND_VERDICT, '0, 8'd0, dsu_pkg::ST_OK);
    r1  = r0;
    n   = 2'd0;
    cur = r0;
    if (ev_trunc_old) begin
      r0 = dsu_pkg::mk_res(dsu_pkg::KIND_VERDICT, '0, 8'd0, dsu_pkg::ST_TRUNCATED);
      n  = 2'd1;
    end
    if (ev_mal || ev_val || ev_ok) begin
      if (ev_mal) begin
        cur = dsu_pkg::mk_res(dsu_pkg::KIND_VERDICT, '0, 8'd0, dsu_pkg::ST_MALFORMED);
      end else begin
        cur = dsu_pkg::mk_res(dsu_pkg::KIND_VALUE, pos_q, b, dsu_pkg::ST_OK);
      end
      if (n == 2'd0) begin
        r0 = cur;
      end else begin
        r1 = cur;
      end
      n = n + 2'd1;
    end
    if (ev_ok || ev_trunc_fin) begin
      cur = dsu_pkg::mk_res(dsu_pkg::KIND_VERDICT, '0, 8'd0,
                            ev_ok ? dsu_pkg::ST_OK : dsu_pkg::ST_TRUNCATED);
      if (n == 2'd0) begin
        r0 = cur;
      end else begin
        r1 = cur;
      end
      n = n + 2'd1;
    end
    r0.run_end = (n == 2'd1);
    r1.run_end = (n == 2'd2);
    res_o.r0    = r0;
    res_o.r1    = r1;
    res_o.count = step_i ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dsu_pkg::PH_IDLE;
      total_q <= '0;
      rlen_q  <= '0;
      slen_q  <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      total_q <= total_d;
      rlen_q  <= rlen_d;
      slen_q  <= slen_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

`ifndef ASSERT_OFF
  a_two_results_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.count != 2'd3)
    else $error("parser produced more than two results");

  a_mal_closes_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev_mal |=> phase_q == dsu_pkg::PH_DONE)
    else $error("malformed byte did not close the frame");

  a_pos_steps_on_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev_val |=> pos_q == $past(pos_q) + 1'b1)
    else $error("output position did not advance on a value byte");
`endif

endmodule

>>> hdl/dsu_res_fifo.sv
// ----------------------------------------------------------------------------
// dsu_res_fifo: result queue
// takes up to two results a cycle and, while the sink pops, hands out one result a cycle
// ----------------------------------------------------------------------------
module dsu_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dsu_pkg::step_res_t push_i,
  output logic               room_o,
  output logic               valid_o,
  output dsu_pkg::res_t      data_o,
  input  logic               pop_i
);

  dsu_pkg::res_t                 mem_q [dsu_pkg::RQ_DEPTH];
  logic [dsu_pkg::RQ_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [dsu_pkg::RQ_CNT_W-1:0]  count_q;
  logic                          pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = pop_i && valid_o;
  // room for a full two-result step
  assign room_o  = count_q <= dsu_pkg::RQ_CNT_W'(dsu_pkg::RQ_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 1'b1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + dsu_pkg::RQ_PTR_W'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + dsu_pkg::RQ_CNT_W'(push_i.count)
               - dsu_pkg::RQ_CNT_W'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_push_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("result pushed without room");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dsu_pkg::RQ_CNT_W'(dsu_pkg::RQ_DEPTH))
    else $error("result queue overfilled");

  a_pop_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.count == 2'd0 |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not drain the queue");
`endif

endmodule

>>> hdl/der_ecdsa_p256_signature_unpacker.sv
// ----------------------------------------------------------------------------
// der_ecdsa_p256_signature_unpacker: DER ECDSA P-256 signature to raw r|s
// checks a DER signature byte by byte and emits indexed r|s bytes plus a verdict
// ----------------------------------------------------------------------------
// throughput: one input item per cycle while the result side keeps up; a byte
//   that yields two results goes out as two items from the result queue
// path: an accepted item waits in the input register, its results in the result queue
// reset: asynchronous, active low; parser idle awaiting a first byte, result
//   queue empty, max_size back to 128

module der_ecdsa_p256_signature_unpacker (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  // configuration: max_size
  input  logic                             cfg_we_i,
  input  logic [dsu_pkg::MAX_SIZE_W-1:0]   cfg_wdata_i,

  // encoded bytes in
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // [7:0] data_byte
  input  logic                             s_axis_tuser_i,  // [0] first
  input  logic                             s_axis_tlast_i,  // final_byte

  // results out
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [15:0]                      m_axis_tdata_o,  // [5:0] sig_index,
                                                            // [13:6] value_byte,
                                                            // [15:14] status
  output logic                             m_axis_tuser_o,  // [0] kind
  output logic                             m_axis_tlast_o   // run_end
);

  logic [dsu_pkg::MAX_SIZE_W-1:0] max_size_q;

  // input register
  logic               in_valid_q;
  dsu_pkg::in_item_t  in_item_q;
  logic               step;
  logic               room;

  dsu_pkg::step_res_t step_res;
  dsu_pkg::res_t      head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= dsu_pkg::MAX_SIZE_RESET;
    end else if (cfg_we_i) begin
      max_size_q <= cfg_wdata_i;
    end
  end

  // the registered item is parsed as soon as the queue can take two results
  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.data_byte  <= s_axis_tdata_i;
      in_item_q.first      <= s_axis_tuser_i;
      in_item_q.final_byte <= s_axis_tlast_i;
    end
  end

  // one pass over the byte: phase update, length checks, result forming
  dsu_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_item_q),
    .max_size_i (max_size_q),
    .res_o      (step_res)
  );

  // results wait here; the input side waits on a busy sink only once the queue lacks room for two
  dsu_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .data_o  (head),
    .pop_i   (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {head.status, head.value_byte, head.sig_index};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.run_end;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the DER ECDSA P-256 signature unpacker
// streams framed encoded bytes with random pacing and corruptions, predicts
// the r|s value bytes and verdicts, and compares every result item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // pacing and run limits
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no item moved
  localparam int unsigned DRAIN_CYCLES = 8;     // margin after the last expected result

  // sideband of a directed item, {first, final_byte}
  localparam logic [1:0] FR_MID   = 2'b00;
  localparam logic [1:0] FR_FIN   = 2'b01;
  localparam logic [1:0] FR_FIRST = 2'b10;
  localparam logic [1:0] FR_BOTH  = 2'b11;

  localparam logic [7:0] SEQ = dsu_pkg::TAG_SEQ;
  localparam logic [7:0] INT = dsu_pkg::TAG_INT;

  // short directed items, {data_byte, first, final_byte}, run at reset max_size
  localparam logic [9:0] DIRECTED [27] = '{
    {8'h55,   FR_MID},                                   // stray byte while idle
    {8'hFF,   FR_BOTH},                                  // bad tag beats final
    {SEQ,     FR_MID},                                   // ignored after verdict
    {SEQ,     FR_FIRST}, {8'd63,  FR_MID},               // total below 64
    {SEQ,     FR_FIRST}, {8'd127, FR_MID},               // total + 2 over max_size
    {SEQ,     FR_FIRST}, {8'd126, FR_MID}, {8'h03, FR_MID},  // bad r tag
    {SEQ,     FR_FIRST}, {8'd68,  FR_MID}, {INT,   FR_MID},
    {8'd31,   FR_MID},                                   // r shorter than 32
    {SEQ,     FR_FIRST}, {8'd68,  FR_MID}, {INT,   FR_MID},
    {8'd67,   FR_MID},                                   // r overruns total
    {SEQ,     FR_FIRST}, {8'd70,  FR_MID},               // restart mid-frame,
    {SEQ,     FR_FIRST}, {8'd64,  FR_FIN},               // then end of input
    {SEQ,     FR_FIRST}, {8'd70,  FR_MID}, {INT,   FR_MID},
    {8'd33,   FR_MID},   {8'h01,  FR_MID}                // non-zero pad of r
  };

  // --------------------------------------------------------------------------
  // scoreboard: tracks the parse state and holds the expected results
  // --------------------------------------------------------------------------
  class sig_scoreboard;
    localparam int unsigned MAX_REPORTS = 40;

    dsu_pkg::phase_e ph;
    int unsigned     max_size;
    int unsigned     total_len;
    int unsigned     r_len;
    int unsigned     s_len;
    int unsigned     byte_cnt;
    int unsigned     out_pos;
    dsu_pkg::res_t   step_q[$];
    dsu_pkg::res_t   expected_q[$];
    int              errors;

    function new();
      ph        = dsu_pkg::PH_IDLE;
      max_size  = dsu_pkg::MAX_SIZE_RESET;
      total_len = 0;
      r_len     = 0;
      s_len     = 0;
      byte_cnt  = 0;
      out_pos   = 0;
      errors    = 0;
    endfunction

    function void add(dsu_pkg::kind_e k, logic [5:0] idx, logic [7:0] val,
                      dsu_pkg::stat_e st);
      dsu_pkg::res_t r;
      r.kind       = k;
      r.sig_index  = idx;
      r.value_byte = val;
      r.status     = st;
      r.run_end    = 1'b0;
      step_q.push_back(r);
    endfunction

    function void close_frame(dsu_pkg::stat_e st);
      add(dsu_pkg::KIND_VERDICT, 6'd0, 8'd0, st);
      ph = dsu_pkg::PH_DONE;
    endfunction

    // one accepted encoded byte: advance the parse and queue its results
    function void note_input(logic [7:0] b, logic first, logic fin);
      int unsigned v;
      int unsigned len;
      v = b;
      step_q.delete();
      if (first) begin
        // an unfinished frame is cut off by the new one
        if (ph != dsu_pkg::PH_IDLE && ph != dsu_pkg::PH_DONE)
          add(dsu_pkg::KIND_VERDICT, 6'd0, 8'd0, dsu_pkg::ST_TRUNCATED);
        total_len = 0;
        r_len     = 0;
        s_len     = 0;
        byte_cnt  = 0;
        out_pos   = 0;
        if (b != dsu_pkg::TAG_SEQ) close_frame(dsu_pkg::ST_MALFORMED);
        else ph = dsu_pkg::PH_LEN;
      end else begin
        case (ph)
          dsu_pkg::PH_LEN: begin
            if (v < dsu_pkg::MIN_TOTAL_LEN || v + 2 > max_size)
              close_frame(dsu_pkg::ST_MALFORMED);
            else begin
              total_len = v;
              ph        = dsu_pkg::PH_RTAG;
            end
          end
          dsu_pkg::PH_RTAG: begin
            if (b != dsu_pkg::TAG_INT) close_frame(dsu_pkg::ST_MALFORMED);
            else ph = dsu_pkg::PH_RLEN;
          end
          dsu_pkg::PH_STAG: begin
            if (b != dsu_pkg::TAG_INT) close_frame(dsu_pkg::ST_MALFORMED);
            else ph = dsu_pkg::PH_SLEN;
          end
          dsu_pkg::PH_RLEN: begin
            if (v < dsu_pkg::COORD_BYTES || v + 4 > total_len + 2)
              close_frame(dsu_pkg::ST_MALFORMED);
            else begin
              r_len    = v;
              byte_cnt = 0;
              ph       = dsu_pkg::PH_RVAL;
            end
          end
          dsu_pkg::PH_SLEN: begin
            if (v < dsu_pkg::COORD_BYTES || v + r_len + 6 > total_len + 2)
              close_frame(dsu_pkg::ST_MALFORMED);
            else begin
              s_len    = v;
              byte_cnt = 0;
              ph       = dsu_pkg::PH_SVAL;
            end
          end
          dsu_pkg::PH_RVAL, dsu_pkg::PH_SVAL: begin
            len = (ph == dsu_pkg::PH_RVAL) ? r_len : s_len;
            if (byte_cnt < len - dsu_pkg::COORD_BYTES && b != 8'd0)
              close_frame(dsu_pkg::ST_MALFORMED);
            else begin
              // pad bytes are dropped, the last 32 of each field go out
              if (byte_cnt >= len - dsu_pkg::COORD_BYTES) begin
                add(dsu_pkg::KIND_VALUE, out_pos[5:0], b, dsu_pkg::ST_OK);
                out_pos = (out_pos + 1) % 64;
              end
              byte_cnt = (byte_cnt + 1) % 256;
              if (byte_cnt >= len) begin
                byte_cnt = 0;
                if (ph == dsu_pkg::PH_RVAL) ph = dsu_pkg::PH_STAG;
                else close_frame(dsu_pkg::ST_OK);
              end
            end
          end
          default: ;
        endcase
      end
      if (fin && ph != dsu_pkg::PH_IDLE && ph != dsu_pkg::PH_DONE)
        close_frame(dsu_pkg::ST_TRUNCATED);
      if (step_q.size() > 0) step_q[step_q.size() - 1].run_end = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void report(string field, int unsigned exp_v, int unsigned act_v);
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", field, exp_v, act_v);
    endfunction

    function void check(dsu_pkg::res_t got);
      dsu_pkg::res_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("result with none expected: kind %0d index %0d value %0d status %0d",
                 got.kind, got.sig_index, got.value_byte, got.status);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.kind != exp_r.kind) report("kind", exp_r.kind, got.kind);
      if (got.sig_index != exp_r.sig_index) report("sig_index", exp_r.sig_index, got.sig_index);
      if (got.value_byte != exp_r.value_byte)
        report("value_byte", exp_r.value_byte, got.value_byte);
      if (got.status != exp_r.status) report("status", exp_r.status, got.status);
      if (got.run_end != exp_r.run_end) report("run_end", exp_r.run_end, got.run_end);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [dsu_pkg::MAX_SIZE_W-1:0] cfg_wdata_i;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [7:0]                     s_axis_tdata_i;   // [7:0] data_byte
  logic                           s_axis_tuser_i;   // [0] first
  logic                           s_axis_tlast_i;   // final_byte
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [15:0]                    m_axis_tdata_o;   // [5:0] sig_index, [13:6] value_byte,
                                                    // [15:14] status
  logic                           m_axis_tuser_o;   // [0] kind
  logic                           m_axis_tlast_o;   // run_end

  der_ecdsa_p256_signature_unpacker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sig_scoreboard sb;
  int            burst_left = 0;   // items left in the current sender burst
  int            items_sent = 0;
  bit            hold_req   = 1'b0; // asks the receiver for a long hold-off

  // --------------------------------------------------------------------------
  // sender tasks: drive at the falling edge, accept at the rising edge
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic first, input logic fin);
    int gap;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= first;
    s_axis_tlast_i  <= fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(b, first, fin);
    items_sent++;
  endtask

  // sender stops and waits for every expected result, then for the pipeline
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_size(input logic [dsu_pkg::MAX_SIZE_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.max_size = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random bytes with random frame marks
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 7) == 0);
  endtask

  // one signature frame, well formed with random content or broken on purpose
  task automatic send_frame();
    logic [7:0] enc_q[$];
    logic       first_q[$];
    logic       fin_q[$];
    int         sel, total, room, rpad, spad, nbytes, pos, lim;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      // total length near its limits, pads filling part of the room
      if (sel == 0) total = 255;
      else if (sel == 1) begin
        lim = int'(sb.max_size) - 2 + int'($urandom_range(0, 1));
        total = (lim > 255) ? 255 : (lim < 64) ? 64 : lim;
      end else total = $urandom_range(dsu_pkg::MIN_TOTAL_LEN, dsu_pkg::MIN_TOTAL_LEN + 3);
      room = total - (2 * dsu_pkg::COORD_BYTES + 4);
      rpad = (room > 0) ? $urandom_range(0, room) : 0;
      spad = (room > rpad) ? $urandom_range(0, room - rpad) : 0;
    end else begin
      rpad  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 3);
      spad  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 3);
      total = 2 * dsu_pkg::COORD_BYTES + 4 + rpad + spad;
      total += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2);
      if (total > 255) total = 255;
      if (2 * dsu_pkg::COORD_BYTES + 4 + rpad + spad > 255) begin
        rpad = rpad % 40;
        spad = spad % 40;
      end
    end

    enc_q.push_back(dsu_pkg::TAG_SEQ);
    enc_q.push_back(8'(total));
    enc_q.push_back(dsu_pkg::TAG_INT);
    enc_q.push_back(8'(dsu_pkg::COORD_BYTES + rpad));
    repeat (rpad) enc_q.push_back(8'd0);
    repeat (dsu_pkg::COORD_BYTES) enc_q.push_back(8'($urandom_range(0, 255)));
    enc_q.push_back(dsu_pkg::TAG_INT);
    enc_q.push_back(8'(dsu_pkg::COORD_BYTES + spad));
    repeat (spad) enc_q.push_back(8'd0);
    repeat (dsu_pkg::COORD_BYTES) enc_q.push_back(8'($urandom_range(0, 255)));
    nbytes = enc_q.size();
    for (int i = 0; i < nbytes; i++) begin
      first_q.push_back(i == 0);
      fin_q.push_back(1'b0);
    end
    // end of input on the closing byte changes nothing
    if ($urandom_range(0, 3) == 0) fin_q[nbytes - 1] = 1'b1;

    // about half the frames get broken in one way
    pos = $urandom_range(1, nbytes - 1);
    case ($urandom_range(0, 12))
      0: enc_q[pos] = 8'($urandom_range(0, 255));
      1: begin
        nbytes     = pos + 1;
        fin_q[pos] = 1'b1;
      end
      2: nbytes = pos;                 // cut off by the next frame
      3: first_q[pos] = 1'b1;          // restart inside the frame
      4: fin_q[pos] = 1'b1;
      5: begin
        if (rpad > 0) enc_q[4 + $urandom_range(0, rpad - 1)] = 8'($urandom_range(1, 255));
        else if (spad > 0)
          enc_q[6 + dsu_pkg::COORD_BYTES + $urandom_range(0, spad - 1)] =
            8'($urandom_range(1, 255));
      end
      6: enc_q[0] = 8'($urandom_range(0, 255));
      default: ;
    endcase

    for (int i = 0; i < nbytes; i++) send_byte(enc_q[i], first_q[i], fin_q[i]);
    // trailing bytes, ignored by the block once the frame is closed
    repeat ($urandom_range(0, 2))
      send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 7) == 0);
  endtask

  task automatic run_frames(input int budget, input bit with_hold);
    int start;
    bit held;
    start = items_sent;
    held  = 1'b0;
    while (items_sent - start < budget) begin
      // halfway through, the receiver holds off while frames keep coming
      if (with_hold && !held && items_sent - start >= budget / 2) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_frame();
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ms_plan [7];
    int items_plan [7];
    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][9:2], DIRECTED[i][1], DIRECTED[i][0]);
    wait_drained();

    // max_size settings: widest, tightest usable, too small, zero, random,
    // back to the reset value, near the top
    ms_plan    = '{257, 66, 2, 0, 0, 128, 255};
    items_plan = '{380, 130, 50, 30, 380, 250, 250};
    ms_plan[4] = $urandom_range(67, 256);
    foreach (ms_plan[i]) begin
      write_max_size(dsu_pkg::MAX_SIZE_W'(ms_plan[i]));
      run_frames(items_plan[i], i == 0 || i == 4);
      wait_drained();
    end

    if (sb.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern steps through four modes, long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int   rx_cycle;
    int   hold_left;
    int   mode;
    logic rdy;
    rx_cycle        = 0;
    hold_left       = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      mode = (rx_cycle / 250) % 4;
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = $urandom_range(0, 3) != 0;
          2:       rdy = (rx_cycle % 3) == 0;
          default: rdy = $urandom_range(0, 3) == 0;
        endcase
      end
      m_axis_tready_i <= rdy;
      rx_cycle++;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : monitor
    dsu_pkg::res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind       = dsu_pkg::kind_e'(m_axis_tuser_o);
      got.sig_index  = m_axis_tdata_o[5:0];
      got.value_byte = m_axis_tdata_o[13:6];
      got.status     = dsu_pkg::stat_e'(m_axis_tdata_o[15:14]);
      got.run_end    = m_axis_tlast_o;
      sb.check(got);
    end
  end

  // watchdog: too long without any item moving on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
hdl/dsu_pkg.sv
hdl/dsu_parser.sv
hdl/dsu_res_fifo.sv
hdl/der_ecdsa_p256_signature_unpacker.sv
verif/tb_top.sv
